FILE: sv/bgw_pkg.sv
package bgw_pkg;

    localparam int unsigned NUM_LANES = 4;
    localparam int unsigned NUM_PTS   = 2;
    localparam int unsigned NUM_W     = 4;

    // axis lanes: main point z/x, dipole point z/x
    localparam int unsigned LANE_MZ = 0;
    localparam int unsigned LANE_MX = 1;
    localparam int unsigned LANE_DZ = 2;
    localparam int unsigned LANE_DX = 3;

    localparam int unsigned PT_MAIN = 0;
    localparam int unsigned PT_DIP  = 1;

    typedef enum logic [2:0] {
        REG_Z_ORIGIN       = 3'd0,
        REG_X_ORIGIN       = 3'd1,
        REG_Z_INV_SPACING  = 3'd2,
        REG_X_INV_SPACING  = 3'd3,
        REG_GRID_NZ        = 3'd4,
        REG_GRID_NX        = 3'd5,
        REG_Z_DIPOLE_SHIFT = 3'd6,
        REG_X_DIPOLE_SHIFT = 3'd7
    } t_reg_idx;

    localparam logic [31:0] INV_SPACING_RST = 32'h0100_0000;
    localparam logic [15:0] GRID_N_RST      = 16'd256;

    typedef struct packed {
        logic signed [31:0] z_coord;
        logic signed [31:0] x_coord;
    } t_req;

    typedef struct packed {
        logic        [31:0] corner_index;
        logic        [15:0] weight_top_left;
        logic        [15:0] weight_bottom_left;
        logic        [15:0] weight_top_right;
        logic        [15:0] weight_bottom_right;
        logic        [31:0] dipole_index;
        logic signed [15:0] dipole_weight_top_left;
        logic signed [15:0] dipole_weight_bottom_left;
        logic signed [15:0] dipole_weight_top_right;
        logic signed [15:0] dipole_weight_bottom_right;
        logic               out_of_bounds;
    } t_res;

endpackage

FILE: sv/bilinear_grid_weights.sv
// Channel  | Handshake                  | Payload
// ---------+----------------------------+------------------------------
// request  | start in, busy out         | i_req (t_req: z, x in Q16.16)
// result   | o_result_valid out         | o_result (t_res)
// config   | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// Six-stage pipeline: difference, split multiply by the inverse spacing,
// grid position, bound check and fractions, weight and index multiplies,
// rounding and output register. One request per cycle; busy stays low.
// Reset (synchronous, active low) clears the valid bits and loads the
// register defaults.
module bilinear_grid_weights
    import bgw_pkg::*;
#(
    parameter bit DIPOLE_ENABLE = 1'b1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_result_valid,
    output t_res        o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic signed [31:0] r_z_origin, r_x_origin, r_z_shift, r_x_shift;
    logic        [31:0] r_z_inv, r_x_inv;
    logic        [15:0] r_nz, r_nx;

    logic [5:0] r_vld;
    logic       accept;
    t_reg_idx   reg_idx;

    assign busy    = 1'b0;
    assign pready  = 1'b1;
    assign accept  = start && !busy;
    assign reg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_origin <= '0;
            r_x_origin <= '0;
            r_z_inv    <= INV_SPACING_RST;
            r_x_inv    <= INV_SPACING_RST;
            r_nz       <= GRID_N_RST;
            r_nx       <= GRID_N_RST;
            r_z_shift  <= '0;
            r_x_shift  <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_Z_ORIGIN:       r_z_origin <= pwdata;
                REG_X_ORIGIN:       r_x_origin <= pwdata;
                REG_Z_INV_SPACING:  r_z_inv    <= pwdata;
                REG_X_INV_SPACING:  r_x_inv    <= pwdata;
                REG_GRID_NZ:        r_nz       <= pwdata[15:0];
                REG_GRID_NX:        r_nx       <= pwdata[15:0];
                REG_Z_DIPOLE_SHIFT: r_z_shift  <= pwdata;
                REG_X_DIPOLE_SHIFT: r_x_shift  <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_Z_ORIGIN:       prdata = r_z_origin;
            REG_X_ORIGIN:       prdata = r_x_origin;
            REG_Z_INV_SPACING:  prdata = r_z_inv;
            REG_X_INV_SPACING:  prdata = r_x_inv;
            REG_GRID_NZ:        prdata = {16'h0, r_nz};
            REG_GRID_NX:        prdata = {16'h0, r_nx};
            REG_Z_DIPOLE_SHIFT: prdata = r_z_shift;
            REG_X_DIPOLE_SHIFT: prdata = r_x_shift;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], accept};
        end
    end

    // stage 1: offsets from the origin
    logic signed [33:0] n_diff [NUM_LANES];
    logic signed [33:0] r_diff [NUM_LANES];

    always_comb begin
        n_diff[LANE_MZ] = 34'(i_req.z_coord) - 34'(r_z_origin);
        n_diff[LANE_MX] = 34'(i_req.x_coord) - 34'(r_x_origin);
        n_diff[LANE_DZ] = 34'(i_req.z_coord) + 34'(r_z_shift) - 34'(r_z_origin);
        n_diff[LANE_DX] = 34'(i_req.x_coord) + 34'(r_x_shift) - 34'(r_x_origin);
    end

    // stage 2: offset times upper and lower half of the inverse spacing
    logic        [31:0] lane_inv [NUM_LANES];
    logic signed [50:0] n_pa [NUM_LANES];
    logic signed [50:0] n_pb [NUM_LANES];
    logic signed [50:0] r_pa [NUM_LANES];
    logic signed [50:0] r_pb [NUM_LANES];

    always_comb begin
        lane_inv[LANE_MZ] = r_z_inv;
        lane_inv[LANE_MX] = r_x_inv;
        lane_inv[LANE_DZ] = r_z_inv;
        lane_inv[LANE_DX] = r_x_inv;
        for (int l = 0; l < NUM_LANES; l++) begin
            n_pa[l] = 51'(r_diff[l]) * 51'($signed({1'b0, lane_inv[l][31:16]}));
            n_pb[l] = 51'(r_diff[l]) * 51'($signed({1'b0, lane_inv[l][15:0]}));
        end
    end

    // stage 3: grid position, floor of product over 2^24
    logic [67:0] full [NUM_LANES];
    logic [43:0] n_pos [NUM_LANES];
    logic [43:0] r_pos [NUM_LANES];

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            full[l]  = {r_pa[l][50], r_pa[l], 16'h0} + {{17{r_pb[l][50]}}, r_pb[l]};
            n_pos[l] = full[l][67:24];
        end
    end

    // stage 4: bound check, cells and corner fractions
    logic [15:0] lane_n   [NUM_LANES];
    logic        lane_oob [NUM_LANES];
    logic [15:0] n_cell [NUM_LANES];
    logic [16:0] n_near [NUM_LANES];
    logic [16:0] n_far  [NUM_LANES];
    logic [15:0] r_cell [NUM_LANES];
    logic [16:0] r_near [NUM_LANES];
    logic [16:0] r_far  [NUM_LANES];
    logic [15:0] lim;
    logic        n_oob4, r_oob4;

    always_comb begin
        lane_n[LANE_MZ] = r_nz;
        lane_n[LANE_MX] = r_nx;
        lane_n[LANE_DZ] = r_nz;
        lane_n[LANE_DX] = r_nx;
        lim = '0;
        for (int l = 0; l < NUM_LANES; l++) begin
            lim         = lane_n[l] - 16'd1;
            lane_oob[l] = r_pos[l][43] || (lane_n[l] < 16'd2)
                          || (r_pos[l][42:0] >= {11'h0, lim, 16'h0});
            n_cell[l]   = r_pos[l][31:16];
            n_far[l]    = {1'b0, r_pos[l][15:0]};
            n_near[l]   = 17'h10000 - {1'b0, r_pos[l][15:0]};
        end
        n_oob4 = lane_oob[LANE_MZ] || lane_oob[LANE_MX]
                 || (DIPOLE_ENABLE && (lane_oob[LANE_DZ] || lane_oob[LANE_DX]));
    end

    // stage 5: corner weight products and row offset
    logic [33:0] n_prod [NUM_PTS][NUM_W];
    logic [33:0] r_prod [NUM_PTS][NUM_W];
    logic [31:0] n_iprod [NUM_PTS];
    logic [31:0] r_iprod [NUM_PTS];
    logic [15:0] r_cellz [NUM_PTS];
    logic        r_oob5;

    always_comb begin
        for (int p = 0; p < NUM_PTS; p++) begin
            n_prod[p][0] = 34'(r_near[2*p]) * 34'(r_near[2*p+1]);
            n_prod[p][1] = 34'(r_far[2*p])  * 34'(r_near[2*p+1]);
            n_prod[p][2] = 34'(r_near[2*p]) * 34'(r_far[2*p+1]);
            n_prod[p][3] = 34'(r_far[2*p])  * 34'(r_far[2*p+1]);
            n_iprod[p]   = 32'(r_cell[2*p+1]) * 32'(r_nz);
        end
    end

    // stage 6: round to Q1.15, build the result
    logic [15:0] wq [NUM_PTS][NUM_W];
    logic [31:0] idx [NUM_PTS];
    logic [33:0] rsum;
    t_res        n_res, r_res;

    always_comb begin
        rsum = '0;
        for (int p = 0; p < NUM_PTS; p++) begin
            for (int k = 0; k < NUM_W; k++) begin
                rsum     = r_prod[p][k] + 34'h10000;
                wq[p][k] = rsum[32:17];
            end
            idx[p] = r_iprod[p] + {16'h0, r_cellz[p]};
        end
        n_res = '0;
        if (r_oob5) begin
            n_res.out_of_bounds = 1'b1;
        end else begin
            n_res.corner_index        = idx[PT_MAIN];
            n_res.weight_top_left     = wq[PT_MAIN][0];
            n_res.weight_bottom_left  = wq[PT_MAIN][1];
            n_res.weight_top_right    = wq[PT_MAIN][2];
            n_res.weight_bottom_right = wq[PT_MAIN][3];
            if (DIPOLE_ENABLE) begin
                n_res.dipole_index               = idx[PT_DIP];
                n_res.dipole_weight_top_left     = 16'h0 - wq[PT_DIP][0];
                n_res.dipole_weight_bottom_left  = 16'h0 - wq[PT_DIP][1];
                n_res.dipole_weight_top_right    = 16'h0 - wq[PT_DIP][2];
                n_res.dipole_weight_bottom_right = 16'h0 - wq[PT_DIP][3];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NUM_LANES; l++) begin
            r_diff[l] <= n_diff[l];
            r_pa[l]   <= n_pa[l];
            r_pb[l]   <= n_pb[l];
            r_pos[l]  <= n_pos[l];
            r_cell[l] <= n_cell[l];
            r_near[l] <= n_near[l];
            r_far[l]  <= n_far[l];
        end
        for (int p = 0; p < NUM_PTS; p++) begin
            for (int k = 0; k < NUM_W; k++) begin
                r_prod[p][k] <= n_prod[p][k];
            end
            r_iprod[p] <= n_iprod[p];
            r_cellz[p] <= r_cell[2*p];
        end
        r_oob4 <= n_oob4;
        r_oob5 <= r_oob4;
        r_res  <= n_res;
    end

    assign o_result_valid = r_vld[5];
    assign o_result       = r_res;

endmodule

FILE: tb/bilinear_grid_weights_tb.sv
module bilinear_grid_weights_tb;
    import bgw_pkg::*;

    localparam bit          DIPOLE_EN   = 1'b1;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASE_ITEMS = 300;
    localparam t_res        OUT_OF_GRID = '{out_of_bounds: 1'b1, default: '0};

    typedef struct {
        bit          is_write;
        t_reg_idx    sel;
        logic [31:0] wdata;
        t_req        pt;
        bit          given;
        t_res        want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_req        i_req;
    logic        o_result_valid;
    t_res        o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic signed [31:0] cfg_z_origin = '0;
    logic signed [31:0] cfg_x_origin = '0;
    logic        [31:0] cfg_z_inv    = INV_SPACING_RST;
    logic        [31:0] cfg_x_inv    = INV_SPACING_RST;
    logic        [15:0] cfg_nz       = GRID_N_RST;
    logic        [15:0] cfg_nx       = GRID_N_RST;
    logic signed [31:0] cfg_z_shift  = '0;
    logic signed [31:0] cfg_x_shift  = '0;

    t_res        pending_stencils[$];
    t_row        stimulus_rows[$];
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;

    bilinear_grid_weights #(
        .DIPOLE_ENABLE(DIPOLE_EN)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req         (i_req),
        .o_result_valid(o_result_valid),
        .o_result      (o_result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic signed [79:0] grid_position(logic signed [35:0] diff,
                                                         logic [31:0] inv);
        logic signed [79:0] d;
        logic signed [79:0] s;
        d = 80'(diff);
        s = {48'd0, inv};
        return (d * s) >>> 24;
    endfunction

    function automatic logic [15:0] to_q15(logic [16:0] a, logic [16:0] b);
        logic [33:0] p;
        p = 34'(a) * 34'(b) + 34'd65536;
        return p[32:17];
    endfunction

    // returns 1 when the point falls off the grid
    function automatic bit locate_point(input logic signed [33:0] zc,
                                        input logic signed [33:0] xc,
                                        output logic [31:0] idx,
                                        output logic [3:0][15:0] w);
        logic signed [35:0] dz;
        logic signed [35:0] dx;
        logic signed [79:0] pz;
        logic signed [79:0] px;
        logic signed [79:0] zlim;
        logic signed [79:0] xlim;
        logic [16:0] fz;
        logic [16:0] fx;
        logic [16:0] nzw;
        logic [16:0] nxw;
        idx = '0;
        w = '0;
        dz = 36'(zc) - 36'(cfg_z_origin);
        dx = 36'(xc) - 36'(cfg_x_origin);
        pz = grid_position(dz, cfg_z_inv);
        px = grid_position(dx, cfg_x_inv);
        zlim = 80'(cfg_nz);
        xlim = 80'(cfg_nx);
        zlim = (zlim - 80'sd1) * 80'sd65536;
        xlim = (xlim - 80'sd1) * 80'sd65536;
        if (pz < 0 || px < 0 || pz >= zlim || px >= xlim) begin
            return 1'b1;
        end
        fz = {1'b0, pz[15:0]};
        fx = {1'b0, px[15:0]};
        nzw = 17'h10000 - fz;
        nxw = 17'h10000 - fx;
        idx = px[47:16] * 32'(cfg_nz) + pz[47:16];
        w[0] = to_q15(nzw, nxw);
        w[1] = to_q15(fz, nxw);
        w[2] = to_q15(nzw, fx);
        w[3] = to_q15(fz, fx);
        return 1'b0;
    endfunction

    function automatic t_res stencil_of(t_req r);
        t_res res;
        logic [31:0] main_idx;
        logic [31:0] dip_idx;
        logic [3:0][15:0] main_w;
        logic [3:0][15:0] dip_w;
        logic signed [33:0] zd;
        logic signed [33:0] xd;
        bit main_out;
        bit dip_out;
        res = '0;
        dip_out = 1'b0;
        dip_idx = '0;
        dip_w = '0;
        main_out = locate_point(34'(r.z_coord), 34'(r.x_coord), main_idx, main_w);
        if (DIPOLE_EN) begin
            zd = 34'(r.z_coord) + 34'(cfg_z_shift);
            xd = 34'(r.x_coord) + 34'(cfg_x_shift);
            dip_out = locate_point(zd, xd, dip_idx, dip_w);
        end
        if (main_out || dip_out) begin
            return OUT_OF_GRID;
        end
        res.corner_index               = main_idx;
        res.weight_top_left            = main_w[0];
        res.weight_bottom_left         = main_w[1];
        res.weight_top_right           = main_w[2];
        res.weight_bottom_right        = main_w[3];
        res.dipole_index               = dip_idx;
        res.dipole_weight_top_left     = 16'd0 - dip_w[0];
        res.dipole_weight_bottom_left  = 16'd0 - dip_w[1];
        res.dipole_weight_top_right    = 16'd0 - dip_w[2];
        res.dipole_weight_bottom_right = 16'd0 - dip_w[3];
        return res;
    endfunction

    // physical extent of the grid along one axis, in Q16.16 coordinate units
    function automatic longint unsigned grid_span(logic [15:0] n, logic [31:0] inv);
        longint unsigned s;
        if (n < 16'd2) begin
            return 64'd1 << 20;
        end
        if (inv == '0) begin
            return 64'h8000_0000;
        end
        s = ((64'(n) - 64'd1) << 40) / inv;
        return (s > 64'h8000_0000) ? 64'h8000_0000 : s;
    endfunction

    function automatic logic [31:0] near_grid(logic [31:0] origin, logic [15:0] n,
                                              logic [31:0] inv);
        longint unsigned s;
        longint off;
        if ($urandom_range(99) < 15) begin
            return $urandom;
        end
        s = grid_span(n, inv);
        off = longint'($urandom_range(0, 32'(s + s / 4))) - longint'(s / 8);
        return origin + 32'(off);
    endfunction

    function automatic logic [31:0] rand_shift(logic [15:0] n, logic [31:0] inv);
        longint unsigned s;
        s = grid_span(n, inv);
        return 32'(longint'($urandom_range(0, 32'(s / 2))) - longint'(s / 4));
    endfunction

    function automatic void add_write(t_reg_idx sel, logic [31:0] value);
        t_row row;
        row.is_write = 1'b1;
        row.sel      = sel;
        row.wdata    = value;
        row.pt       = '0;
        row.given    = 1'b0;
        row.want     = '0;
        stimulus_rows = {stimulus_rows, row};
    endfunction

    function automatic void add_point(logic [31:0] z, logic [31:0] x, bit given, t_res want);
        t_row row;
        row.is_write   = 1'b0;
        row.sel        = REG_Z_ORIGIN;
        row.wdata      = '0;
        row.pt.z_coord = z;
        row.pt.x_coord = x;
        row.given      = given;
        row.want       = want;
        stimulus_rows = {stimulus_rows, row};
    endfunction

    task automatic issue_point(t_req r, bit given, t_res want);
        t_res next_want;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        next_want = given ? want : stencil_of(r);
        pending_stencils = {pending_stencils, next_want};
    endtask

    task automatic idle_gap(int unsigned pct);
        while ($urandom_range(99) < pct) begin
            start <= 1'b0;
            i_req <= {$urandom, $urandom};
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_stencils.size() != 0) @(posedge i_clk);
    endtask

    // leaves the bus in the access phase; the caller releases psel
    task automatic apb_write(t_reg_idx sel, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (sel)
            REG_Z_ORIGIN:       cfg_z_origin = value;
            REG_X_ORIGIN:       cfg_x_origin = value;
            REG_Z_INV_SPACING:  cfg_z_inv    = value;
            REG_X_INV_SPACING:  cfg_x_inv    = value;
            REG_GRID_NZ:        cfg_nz       = value[15:0];
            REG_GRID_NX:        cfg_nx       = value[15:0];
            REG_Z_DIPOLE_SHIFT: cfg_z_shift  = value;
            REG_X_DIPOLE_SHIFT: cfg_x_shift  = value;
            default: ;
        endcase
    endtask

    task automatic check_field(string label, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t %s: expected %h, got %h", $time, label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("bilinear_grid_weights: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_result_valid) begin
            if (pending_stencils.size() == 0) begin
                $display("%0t unexpected result: expected none, got %h", $time, o_result);
                mismatches++;
            end else begin
                want = pending_stencils.pop_front();
                check_field("corner_index", want.corner_index, o_result.corner_index);
                check_field("weight_top_left", 32'(want.weight_top_left),
                            32'(o_result.weight_top_left));
                check_field("weight_bottom_left", 32'(want.weight_bottom_left),
                            32'(o_result.weight_bottom_left));
                check_field("weight_top_right", 32'(want.weight_top_right),
                            32'(o_result.weight_top_right));
                check_field("weight_bottom_right", 32'(want.weight_bottom_right),
                            32'(o_result.weight_bottom_right));
                check_field("dipole_index", want.dipole_index, o_result.dipole_index);
                check_field("dipole_weight_top_left", 32'(want.dipole_weight_top_left),
                            32'(o_result.dipole_weight_top_left));
                check_field("dipole_weight_bottom_left",
                            32'(want.dipole_weight_bottom_left),
                            32'(o_result.dipole_weight_bottom_left));
                check_field("dipole_weight_top_right", 32'(want.dipole_weight_top_right),
                            32'(o_result.dipole_weight_top_right));
                check_field("dipole_weight_bottom_right",
                            32'(want.dipole_weight_bottom_right),
                            32'(o_result.dipole_weight_bottom_right));
                check_field("out_of_bounds", 32'(want.out_of_bounds),
                            32'(o_result.out_of_bounds));
            end
        end
    end

    initial begin
        logic [31:0] zo;
        logic [31:0] xo;
        logic [31:0] zi;
        logic [31:0] xi;
        logic [31:0] zs;
        logic [31:0] xs;
        logic [15:0] nz;
        logic [15:0] nx;
        int unsigned idle_pct;
        t_req pt;

        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_req   <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset grid: unit spacing, 256 x 256, dipole on top of the point
        add_point(32'h0000_0000, 32'h0000_0000, 1'b1,
                  t_res'{32'd0, 16'd32768, 16'd0, 16'd0, 16'd0,
                         32'd0, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b0});
        add_point(32'h0000_8000, 32'h0000_0000, 1'b1,
                  t_res'{32'd0, 16'd16384, 16'd16384, 16'd0, 16'd0,
                         32'd0, 16'hC000, 16'hC000, 16'h0000, 16'h0000, 1'b0});
        add_point(32'h0000_FFFF, 32'h0000_0000, 1'b1,
                  t_res'{32'd0, 16'd1, 16'd32768, 16'd0, 16'd0,
                         32'd0, 16'hFFFF, 16'h8000, 16'h0000, 16'h0000, 1'b0});
        add_point(32'hFFFF_FFFF, 32'h0000_0000, 1'b1, OUT_OF_GRID);
        add_point(32'h0000_0000, 32'h7FFF_FFFF, 1'b1, OUT_OF_GRID);
        add_point(32'h8000_0000, 32'h8000_0000, 1'b1, OUT_OF_GRID);
        add_point(32'h00FF_0000, 32'h0000_0000, 1'b1, OUT_OF_GRID);
        add_point(32'h00FE_FFFF, 32'h00FE_FFFF, 1'b0, '0);
        add_point(32'h0012_3456, 32'h00AB_CDEF, 1'b0, '0);
        add_write(REG_Z_DIPOLE_SHIFT, 32'h0001_0000);
        add_point(32'h00FE_8000, 32'h0001_0000, 1'b1, OUT_OF_GRID);
        add_write(REG_X_DIPOLE_SHIFT, 32'hFFFF_0000);
        add_point(32'h0001_0000, 32'h0001_0000, 1'b0, '0);
        add_point(32'h0000_0000, 32'h0000_0000, 1'b1, OUT_OF_GRID);
        add_write(REG_Z_INV_SPACING, 32'h0000_0000);
        add_point(32'h7FFF_FFFF, 32'h0002_0000, 1'b0, '0);
        add_point(32'h8000_0000, 32'h0003_0000, 1'b0, '0);
        add_write(REG_GRID_NZ, 32'h0000_0001);
        add_point(32'h0001_0000, 32'h0001_0000, 1'b1, OUT_OF_GRID);
        add_write(REG_GRID_NZ, 32'h0000_0000);
        add_point(32'h0001_0000, 32'h0001_0000, 1'b1, OUT_OF_GRID);
        add_write(REG_GRID_NZ, 32'hFFFF_0002);
        add_point(32'h0001_0000, 32'h0001_0000, 1'b0, '0);
        add_write(REG_GRID_NX, 32'h0000_0001);
        add_point(32'h0001_0000, 32'h0001_0000, 1'b1, OUT_OF_GRID);
        add_write(REG_GRID_NX, 32'h0000_FFFF);
        add_write(REG_X_INV_SPACING, 32'hFFFF_FFFF);
        add_write(REG_Z_ORIGIN, 32'h7FFF_FFFF);
        add_write(REG_X_ORIGIN, 32'h8000_0000);
        add_point(32'h7FFF_FFFF, 32'h8001_0000, 1'b0, '0);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0);
        add_write(REG_X_DIPOLE_SHIFT, 32'h8000_0000);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0);

        foreach (stimulus_rows[i]) begin
            if (stimulus_rows[i].is_write) begin
                wait_drained();
                apb_write(stimulus_rows[i].sel, stimulus_rows[i].wdata);
                if (i + 1 == stimulus_rows.size() || !stimulus_rows[i + 1].is_write) begin
                    psel    <= 1'b0;
                    penable <= 1'b0;
                end
            end else begin
                issue_point(stimulus_rows[i].pt, stimulus_rows[i].given,
                            stimulus_rows[i].want);
            end
        end

        for (int p = 0; p < 6; p++) begin
            zo = 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
            xo = 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
            zi = $urandom_range(32'h0040_0000, 32'h0400_0000);
            xi = $urandom_range(32'h0040_0000, 32'h0400_0000);
            nz = 16'($urandom_range(2, 300));
            nx = 16'($urandom_range(2, 300));
            idle_pct = 0;
            case (p)
                1: begin
                    zo = 32'h8000_0000;
                    xo = 32'h8000_0000;
                    zi = 32'hFFFF_FFFF;
                    xi = 32'hFFFF_FFFF;
                    nz = 16'hFFFF;
                    nx = 16'hFFFF;
                    idle_pct = 75;
                end
                2: begin
                    zo = $urandom;
                    xo = $urandom;
                    zi = 32'h0000_0000;
                    nz = 16'd2;
                    nx = 16'd2;
                end
                3: begin
                    zo = $urandom;
                    xo = $urandom;
                    zi = $urandom;
                    xi = $urandom;
                    nz = 16'($urandom_range(2, 65535));
                    nx = 16'($urandom_range(2, 65535));
                    idle_pct = 22;
                end
                4: begin
                    zo = 32'h0000_0000;
                    xo = 32'h0000_0000;
                    zi = 32'h0000_0001;
                    xi = 32'h0000_0001;
                    nz = 16'($urandom_range(2, 16));
                    nx = 16'($urandom_range(2, 16));
                end
                5: idle_pct = 22;
                default: ;
            endcase
            zs = (p == 4) ? 32'h7FFF_FFFF : rand_shift(nz, zi);
            xs = (p == 4) ? 32'h7FFF_FFFF : rand_shift(nx, xi);

            wait_drained();
            apb_write(REG_Z_ORIGIN, zo);
            apb_write(REG_X_ORIGIN, xo);
            apb_write(REG_Z_INV_SPACING, zi);
            apb_write(REG_X_INV_SPACING, xi);
            apb_write(REG_GRID_NZ, {16'd0, nz});
            apb_write(REG_GRID_NX, {16'd0, nx});
            apb_write(REG_Z_DIPOLE_SHIFT, zs);
            apb_write(REG_X_DIPOLE_SHIFT, xs);
            psel    <= 1'b0;
            penable <= 1'b0;

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 2) begin
                    wait_drained();
                end
                idle_gap(idle_pct);
                pt.z_coord = near_grid(cfg_z_origin, cfg_nz, cfg_z_inv);
                pt.x_coord = near_grid(cfg_x_origin, cfg_nx, cfg_x_inv);
                issue_point(pt, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("bilinear_grid_weights: match");
        end else begin
            $display("bilinear_grid_weights: mismatch");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/bgw_pkg.sv
sv/bilinear_grid_weights.sv
tb/bilinear_grid_weights_tb.sv
